[src/fixed_point_alu_defines.svh]
// Assertion macros for the fixed-point ALU.
// Included by the top level only; no other dependencies.
`ifndef FIXED_POINT_ALU_DEFINES_SVH
`define FIXED_POINT_ALU_DEFINES_SVH
// Assert that a implies b on the next edge.
`define FPA_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
// Assert that a implies b on the same edge.
`define FPA_ASSERT_NOW(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`endif

[src/fpa_pkg.sv]
// Package for the fixed-point ALU: widths, opcodes, status codes, cell payload.
// No dependencies.
package fpa_pkg;
    localparam int WordWidth = 32;
    localparam int FracBits  = 8;
    localparam int QuoBits   = WordWidth + FracBits + 1;  // quotient bits kept
    localparam int NumCells  = QuoBits;

    typedef enum logic [3:0] {
        CMD_ADD = 4'd0, CMD_SUB = 4'd1, CMD_MUL = 4'd2, CMD_DIV = 4'd3,
        CMD_MIN = 4'd4, CMD_MAX = 4'd5, CMD_INC = 4'd6, CMD_DEC = 4'd7,
        CMD_FROM_INT = 4'd8, CMD_TO_INT = 4'd9, CMD_CMP = 4'd10
    } t_cmd;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_OVF = 2'd1;
    localparam logic [1:0] ST_DIV0 = 2'd2;

    // Item travelling down the cell row.
    typedef struct packed {
        logic                   valid;
        logic                   is_div;
        logic                   div0;
        logic                   neg;
        logic [WordWidth-1:0]   res;     // finished result for non-divide items
        logic [1:0]             st;
        logic [2:0]             flags;   // {gt, eq, lt}
        logic [WordWidth:0]     rem;     // partial remainder
        logic [QuoBits-1:0]     num;     // numerator bits still to shift in, MSB first
        logic [QuoBits-1:0]     quo;
        logic [WordWidth-1:0]   den;
    } t_item;
endpackage

[src/fpa_front.sv]
// Front cell: decodes the request and computes all non-divide operations.
// Depends on fpa_pkg.
module fpa_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [3:0]                  i_cmd,
    input  logic [fpa_pkg::WordWidth-1:0] i_a,
    input  logic [fpa_pkg::WordWidth-1:0] i_b,
    output fpa_pkg::t_item              o_item
);
    import fpa_pkg::*;
    localparam int W = WordWidth;
    localparam logic [W-1:0] MaxPos = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MinNeg = {1'b1, {(W-1){1'b0}}};

    logic [W-1:0] ma, mb, sum, dif, inc, dec, fi, ti;
    logic         sa, sb, lt, gt, eq;
    logic [2*W-1:0] prod;
    logic [2*W-1:0] prnd;
    logic [2*W-FracBits-1:0] pm;
    logic         neg;
    logic         r_valid;
    t_item        n_it, r_it;

    always_comb begin
        sa   = i_a[W-1];
        sb   = i_b[W-1];
        ma   = sa ? (~i_a + 1'b1) : i_a;
        mb   = sb ? (~i_b + 1'b1) : i_b;
        neg  = sa ^ sb;
        sum  = i_a + i_b;
        dif  = i_a - i_b;
        inc  = i_a + 1'b1;
        dec  = i_a - 1'b1;
        fi   = i_a << FracBits;
        ti   = W'($signed(i_a) >>> FracBits);
        lt   = $signed(i_a) < $signed(i_b);
        gt   = $signed(i_a) > $signed(i_b);
        eq   = i_a == i_b;
        prod = ma * mb;
        prnd = prod + (2*W)'(1 << (FracBits - 1));
        pm   = prnd[2*W-1:FracBits];

        n_it = '0;
        n_it.valid = i_valid;
        n_it.neg   = neg;
        n_it.st    = ST_OK;
        n_it.den   = mb;
        n_it.num   = QuoBits'({ma, FracBits'(0)});
        unique case (i_cmd)
            CMD_ADD: begin
                n_it.res = sum;
                if (sa == sb && sum[W-1] != sa) begin
                    n_it.res = sa ? MinNeg : MaxPos; n_it.st = ST_OVF;
                end
            end
            CMD_SUB: begin
                n_it.res = dif;
                if (sa != sb && dif[W-1] != sa) begin
                    n_it.res = sa ? MinNeg : MaxPos; n_it.st = ST_OVF;
                end
            end
            CMD_MUL: begin
                if (neg ? (pm > (2*W-FracBits)'(MinNeg)) : (pm > (2*W-FracBits)'(MaxPos)))
                begin
                    n_it.res = neg ? MinNeg : MaxPos; n_it.st = ST_OVF;
                end else begin
                    n_it.res = neg ? (~pm[W-1:0] + 1'b1) : pm[W-1:0];
                end
            end
            CMD_DIV: begin
                n_it.is_div = 1'b1;
                n_it.div0   = (i_b == '0);
            end
            CMD_MIN: n_it.res = gt ? i_b : i_a;
            CMD_MAX: n_it.res = gt ? i_a : i_b;
            CMD_INC: begin
                n_it.res = inc;
                if (!sa && inc[W-1]) begin n_it.res = MaxPos; n_it.st = ST_OVF; end
            end
            CMD_DEC: begin
                n_it.res = dec;
                if (sa && !dec[W-1]) begin n_it.res = MinNeg; n_it.st = ST_OVF; end
            end
            CMD_FROM_INT: begin
                n_it.res = fi;
                if (W'($signed(fi) >>> FracBits) != i_a) begin
                    n_it.res = sa ? MinNeg : MaxPos; n_it.st = ST_OVF;
                end
            end
            CMD_TO_INT: n_it.res = ti;
            CMD_CMP:    n_it.flags = {gt, eq, lt};
            default:    n_it.res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= n_it.valid;
        end
    end
    // payload fields need no reset
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_it <= n_it;
        end
    end

    always_comb begin
        o_item = r_it;
        o_item.valid = r_valid;
    end
endmodule

[src/fpa_div_cell.sv]
// One restoring-division cell: produces one quotient bit per item per cycle while i_en is high.
// Depends on fpa_pkg.
module fpa_div_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  fpa_pkg::t_item i_item,
    output fpa_pkg::t_item o_item
);
    import fpa_pkg::*;
    logic       r_valid;
    t_item      r_it, n_it;
    logic [WordWidth:0] sh;
    logic       ge;

    always_comb begin
        n_it = i_item;
        sh   = {i_item.rem[WordWidth-1:0], i_item.num[QuoBits-1]};
        ge   = sh >= {1'b0, i_item.den};
        n_it.num = {i_item.num[QuoBits-2:0], 1'b0};
        n_it.rem = ge ? (sh - {1'b0, i_item.den}) : sh;
        n_it.quo = {i_item.quo[QuoBits-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_item.valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_it <= n_it;
        end
    end

    always_comb begin
        o_item = r_it;
        o_item.valid = r_valid;
    end
endmodule

[src/fpa_tail.sv]
// Last stage: rounds and saturates the quotient or flags div0; forms the result.
// Depends on fpa_pkg.
module fpa_tail (
    input  fpa_pkg::t_item              i_item,
    output logic [fpa_pkg::WordWidth-1:0] o_res,
    output logic [1:0]                  o_st,
    output logic [2:0]                  o_flags
);
    import fpa_pkg::*;
    localparam int W = WordWidth;
    logic [QuoBits:0] q;
    logic [W:0]       lim;

    always_comb begin
        // round half away from zero: remainder*2 >= divisor
        q   = {1'b0, i_item.quo} +
              (QuoBits+1)'(({i_item.rem, 1'b0}) >= {2'b0, i_item.den});
        lim = i_item.neg ? {2'b01, {(W-1){1'b0}}} : {2'b00, {(W-1){1'b1}}};
        o_flags = i_item.flags;
        o_res   = i_item.res;
        o_st    = i_item.st;
        if (i_item.is_div) begin
            if (i_item.div0) begin
                o_res = '0;
                o_st  = ST_DIV0;
            end else if (q > (QuoBits+1)'(lim)) begin
                o_res = i_item.neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
                o_st  = ST_OVF;
            end else begin
                o_res = i_item.neg ? (~q[W-1:0] + 1'b1) : q[W-1:0];
                o_st  = ST_OK;
            end
        end
    end
endmodule

[src/fixed_point_alu.sv]
// Top level of the signed Q24.8 fixed-point ALU with a stream interface.
// Depends on fpa_pkg, fpa_front, fpa_div_cell, fpa_tail and the defines header.
//
// Accepts one request every cycle while the output is not stalled; each result
// passes one front cell, 41 division cells each resolving one quotient bit, then
// the output register. All commands take that same path, so results
// leave in order. The whole row advances only when the output register is
// free or being taken; a stalled output stops the row.
`include "fixed_point_alu_defines.svh"
module fixed_point_alu (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // operand_a[31:0], operand_b[63:32]
    input  logic [3:0]  s_axis_tuser,   // cmd[3:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // result[31:0], is_less, is_equal, is_greater,
                                        // status[36:35], zero pad
);
    import fpa_pkg::*;

    t_item       w_item [NumCells+1];
    logic        w_en;
    logic [WordWidth-1:0] w_res;
    logic [1:0]  w_st;
    logic [2:0]  w_flags;
    logic        r_out_valid;
    logic [39:0] r_out_data;

    // advance when output is empty or being drained
    assign w_en = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_en;

    fpa_front u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_valid(s_axis_tvalid),
        .i_cmd  (s_axis_tuser),
        .i_a    (s_axis_tdata[31:0]),
        .i_b    (s_axis_tdata[63:32]),
        .o_item (w_item[0])
    );

    for (genvar g = 0; g < NumCells; g++) begin : g_cell
        fpa_div_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_item (w_item[g]),
            .o_item (w_item[g+1])
        );
    end

    fpa_tail u_tail (
        .i_item (w_item[NumCells]),
        .o_res  (w_res),
        .o_st   (w_st),
        .o_flags(w_flags)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_item[NumCells].valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_data <= {3'b000, w_st, w_flags[2], w_flags[1], w_flags[0], w_res};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    `FPA_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata))
    `FPA_ASSERT_NOW(a_flags_excl, i_clk, i_rst_n, m_axis_tvalid,
        $countones(m_axis_tdata[34:32]) <= 1)
    `FPA_ASSERT_NOW(a_status_code, i_clk, i_rst_n, m_axis_tvalid,
        m_axis_tdata[36:35] != 2'd3)
endmodule
